FILE: rtl/lifo_stack_with_multipop_assert.svh
// assertion macros for the bounded stack with multipop
// expects signals named clk and rst_n in the module that includes it
`ifndef LIFO_STACK_WITH_MULTIPOP_ASSERT_SVH
`define LIFO_STACK_WITH_MULTIPOP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LSTK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack assertion failed");

// consequent checked in the cycle after the antecedent
`define LSTK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack assertion failed");

`endif

FILE: rtl/lstk_pkg.sv
// shared types and constants of the bounded stack with multipop
// no dependencies
package lstk_pkg;

    // request codes
    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_MULTI = 2'd2;

    // result status codes
    localparam logic [2:0] STAT_PUSHED    = 3'd0;
    localparam logic [2:0] STAT_POPPED    = 3'd1;
    localparam logic [2:0] STAT_OVERFLOW  = 3'd2;
    localparam logic [2:0] STAT_UNDERFLOW = 3'd3;
    localparam logic [2:0] STAT_NONE      = 3'd4;

    // most entries one multipop may remove
    localparam int MAX_RESULTS = 16;
    localparam int REM_W       = $clog2(MAX_RESULTS + 1);

    // capacity register
    localparam int          CAP_W     = 5;
    localparam logic [4:0]  CAP_RESET = 5'd16;

    typedef logic signed [31:0] value_t;

    // one request word
    typedef struct packed {
        logic [1:0]  req_type;
        value_t      push_value;
        logic [7:0]  pop_count;
    } req_word_t;

    // one result word
    typedef struct packed {
        value_t      popped_value;
        logic [2:0]  status;
        logic        last;
        logic [4:0]  occupancy;
        logic [31:0] push_total;
        logic [31:0] pop_total;
        logic [31:0] multipop_elements;
        logic [31:0] multipop_calls;
    } rsp_word_t;

    // shift controls for the cell chain
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctl_t;

endpackage

FILE: rtl/lstk_cell.sv
// one storage cell of the shifting stack chain
// depends on lstk_pkg for the value and control types
module lstk_cell
(
    input  logic               clk,
    input  lstk_pkg::cell_ctl_t ctl,
    input  lstk_pkg::value_t   from_above,
    input  lstk_pkg::value_t   from_below,
    output lstk_pkg::value_t   data
);
    import lstk_pkg::*;

    value_t data_reg;

    // push moves words down the chain, pop moves them up
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            data_reg <= from_above;
        end
        else if (ctl.pop)
        begin
            data_reg <= from_below;
        end
    end

    assign data = data_reg;

endmodule

FILE: rtl/lifo_stack_with_multipop.sv
// Bounded LIFO stack with push, pop and multipop. The entries live in a chain of
// DEPTH cells with the top of stack always in the first cell; a push shifts the
// chain down by one and a pop shifts it up by one. Push, pop, overflow, underflow
// and a multipop that removes nothing each give one result word.
// A multipop that removes n entries (n = min(pop_count, occupancy, 16)) is first
// decoded, then gives one result per removed entry, since the chain moves one place
// per cycle. No request is taken until its last result is in the output register.
// Results wait in a single output register; while it holds a word the consumer has
// not taken, no request is accepted and a multipop does not advance. Entries need no
// clearing after reset. The capacity register may be written at any time the stack
// is idle; values above DEPTH act as DEPTH.
// depends on lstk_pkg, lstk_cell and lifo_stack_with_multipop_assert.svh
module lifo_stack_with_multipop
#(
    parameter int DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lstk_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output lstk_pkg::rsp_word_t rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [4:0]          cfg_data
);
    import lstk_pkg::*;

    `include "lifo_stack_with_multipop_assert.svh"

    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

    typedef enum logic {S_IDLE, S_MULTI} state_t;

    state_t              state_reg, state_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [CAP_W-1:0]    cap_reg;
    logic [REM_W-1:0]    remain_reg, remain_next;
    logic [31:0]         push_cnt_reg, push_cnt_next;
    logic [31:0]         pop_cnt_reg, pop_cnt_next;
    logic [31:0]         elem_cnt_reg, elem_cnt_next;
    logic [31:0]         call_cnt_reg, call_cnt_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_word_t           rsp_reg, rsp_next;

    cell_ctl_t           cell_ctl;
    value_t              cell_data [DEPTH];

    logic                slot_free;
    logic                req_take;
    logic                stack_full;
    logic                emit;
    value_t              emit_value;
    logic [2:0]          emit_status;
    logic                emit_last;
    logic [8:0]          want_ext;
    logic [8:0]          fill_ext9;
    logic [8:0]          take_a;
    logic [8:0]          take_n;

    // chain of storage cells, top of stack in cell zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        value_t above;
        value_t below;
        if (i == 0)
        begin : g_top
            assign above = req.push_value;
        end
        else
        begin : g_mid
            assign above = cell_data[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_bot
            assign below = cell_data[i];
        end
        else
        begin : g_up
            assign below = cell_data[i+1];
        end
        lstk_cell u_cell
        (
            .clk        (clk),
            .ctl        (cell_ctl),
            .from_above (above),
            .from_below (below),
            .data       (cell_data[i])
        );
    end

    // handshake
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE) && slot_free;
    assign req_take  = req_valid && req_ready;
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // full when at capacity or at the chain length
    assign stack_full = (CMP_W'(fill_reg) >= CMP_W'(cap_reg))
                     || (CMP_W'(fill_reg) >= CMP_W'(DEPTH));

    // multipop count, capped by occupancy and the result limit
    assign want_ext  = 9'(req.pop_count);
    assign fill_ext9 = 9'(fill_reg);
    assign take_a    = (want_ext < fill_ext9) ? want_ext : fill_ext9;
    assign take_n    = (take_a < 9'(MAX_RESULTS)) ? take_a : 9'(MAX_RESULTS);

    // request decode and multipop sequencing
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        remain_next   = remain_reg;
        push_cnt_next = push_cnt_reg;
        pop_cnt_next  = pop_cnt_reg;
        elem_cnt_next = elem_cnt_reg;
        call_cnt_next = call_cnt_reg;
        cell_ctl      = '0;
        emit          = 1'b0;
        emit_value    = '0;
        emit_status   = STAT_NONE;
        emit_last     = 1'b1;

        if (state_reg == S_IDLE)
        begin
            if (req_take)
            begin
                case (req.req_type)
                    REQ_PUSH:
                    begin
                        emit = 1'b1;
                        if (stack_full)
                        begin
                            emit_status = STAT_OVERFLOW;
                        end
                        else
                        begin
                            cell_ctl.push = 1'b1;
                            fill_next     = fill_reg + 1'b1;
                            push_cnt_next = push_cnt_reg + 32'd1;
                            emit_status   = STAT_PUSHED;
                        end
                    end
                    REQ_POP:
                    begin
                        emit = 1'b1;
                        if (fill_reg == '0)
                        begin
                            emit_value  = '1;
                            emit_status = STAT_UNDERFLOW;
                        end
                        else
                        begin
                            cell_ctl.pop = 1'b1;
                            fill_next    = fill_reg - 1'b1;
                            pop_cnt_next = pop_cnt_reg + 32'd1;
                            emit_value   = cell_data[0];
                            emit_status  = STAT_POPPED;
                        end
                    end
                    REQ_MULTI:
                    begin
                        if (take_n == '0)
                        begin
                            emit          = 1'b1;
                            call_cnt_next = call_cnt_reg + 32'd1;
                            emit_status   = STAT_NONE;
                        end
                        else
                        begin
                            remain_next = REM_W'(take_n);
                            state_next  = S_MULTI;
                        end
                    end
                    default:
                    begin
                        emit = 1'b0;
                    end
                endcase
            end
        end
        else if (slot_free)
        begin
            // one entry per cycle while the output slot is free
            emit          = 1'b1;
            cell_ctl.pop  = 1'b1;
            fill_next     = fill_reg - 1'b1;
            pop_cnt_next  = pop_cnt_reg + 32'd1;
            elem_cnt_next = elem_cnt_reg + 32'd1;
            remain_next   = remain_reg - 1'b1;
            emit_value    = cell_data[0];
            emit_status   = STAT_POPPED;
            emit_last     = (remain_reg == REM_W'(1));
            if (emit_last)
            begin
                call_cnt_next = call_cnt_reg + 32'd1;
                state_next    = S_IDLE;
            end
        end
    end

    // result word assembly
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        if (emit)
        begin
            rsp_valid_next             = 1'b1;
            rsp_next.popped_value      = emit_value;
            rsp_next.status            = emit_status;
            rsp_next.last              = emit_last;
            rsp_next.occupancy         = 5'(fill_next);
            rsp_next.push_total        = push_cnt_next;
            rsp_next.pop_total         = pop_cnt_next;
            rsp_next.multipop_elements = elem_cnt_next;
            rsp_next.multipop_calls    = call_cnt_next;
        end
    end

    // control state, counters and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            cap_reg       <= CAP_RESET;
            remain_reg    <= '0;
            push_cnt_reg  <= '0;
            pop_cnt_reg   <= '0;
            elem_cnt_reg  <= '0;
            call_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            remain_reg    <= remain_next;
            push_cnt_reg  <= push_cnt_next;
            pop_cnt_reg   <= pop_cnt_next;
            elem_cnt_reg  <= elem_cnt_next;
            call_cnt_reg  <= call_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // occupancy never exceeds the chain length
    `LSTK_ASSERT_NOW(a_fill_bound, 1'b1, CMP_W'(fill_reg) <= CMP_W'(DEPTH))
    // a multipop in progress always has entries left to remove
    `LSTK_ASSERT_NOW(a_multi_remain, state_reg == S_MULTI, remain_reg != '0)
    // a result that is not the last one belongs to a running multipop
    `LSTK_ASSERT_NOW(a_not_last, rsp_valid_reg && !rsp_reg.last, state_reg == S_MULTI)
    // each multipop step removes exactly one entry
    `LSTK_ASSERT_NEXT(a_multi_step, state_reg == S_MULTI && slot_free,
        fill_reg == $past(fill_reg) - 1'b1)

endmodule

FILE: dv/lifo_stack_with_multipop_tb.sv
// self-checking testbench for the bounded stack with push, pop and multipop
// drives request words and capacity writes, predicts every result word and compares
// depends on lstk_pkg and lifo_stack_with_multipop
module lifo_stack_with_multipop_tb;

    import lstk_pkg::*;

    localparam int         DEPTH         = 16;
    localparam logic [1:0] REQ_RESERVED  = 2'd3;
    localparam int         SETTLE_CYCLES = 24;

    logic         clk;
    logic         rst_n     = 1'b0;
    logic         req_valid = 1'b0;
    logic         req_ready;
    req_word_t    req       = '0;
    logic         rsp_valid;
    logic         rsp_ready = 1'b0;
    rsp_word_t    rsp;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [4:0]   cfg_data  = CAP_RESET;

    // stimulus and expectation stores
    req_word_t    pending_req[$];
    rsp_word_t    expected_rsp[$];
    int           words_loaded = 0;
    int           words_taken  = 0;
    logic         req_taken    = 1'b0;

    // idling controls
    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    logic         steady        = 1'b0;
    int           stretch_left  = 0;

    // shadow of the stack and its counters
    value_t       shadow_mem[DEPTH];
    int           shadow_fill  = 0;
    logic [31:0]  push_cnt     = '0;
    logic [31:0]  pop_cnt      = '0;
    logic [31:0]  multi_elems  = '0;
    logic [31:0]  multi_calls  = '0;
    logic [4:0]   cap_setting  = CAP_RESET;

    // run statistics
    int           errors       = 0;
    int           results_seen = 0;
    int           overflows    = 0;
    int           underflows   = 0;
    int           deepest_multi = 0;

    lifo_stack_with_multipop #(.DEPTH(DEPTH)) uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // queue one result word built from the current shadow state
    function automatic void note_result(input value_t v, input logic [2:0] st,
                                        input logic fin);
        rsp_word_t w;
        w.popped_value      = v;
        w.status            = st;
        w.last              = fin;
        w.occupancy         = shadow_fill[4:0];
        w.push_total        = push_cnt;
        w.pop_total         = pop_cnt;
        w.multipop_elements = multi_elems;
        w.multipop_calls    = multi_calls;
        expected_rsp.push_back(w);
    endfunction

    // work out the result words caused by one accepted request word
    function automatic void predict_stack(input req_word_t w);
        int usable;
        int n;
        int i;
        value_t v;
        usable = (cap_setting > DEPTH) ? DEPTH : cap_setting;
        case (w.req_type)
            REQ_PUSH:
            begin
                if (shadow_fill >= usable || shadow_fill >= DEPTH)
                begin
                    overflows++;
                    note_result('0, STAT_OVERFLOW, 1'b1);
                end
                else
                begin
                    shadow_mem[shadow_fill] = w.push_value;
                    shadow_fill++;
                    push_cnt++;
                    note_result('0, STAT_PUSHED, 1'b1);
                end
            end
            REQ_POP:
            begin
                if (shadow_fill == 0)
                begin
                    underflows++;
                    note_result(-32'sd1, STAT_UNDERFLOW, 1'b1);
                end
                else
                begin
                    shadow_fill--;
                    pop_cnt++;
                    note_result(shadow_mem[shadow_fill], STAT_POPPED, 1'b1);
                end
            end
            REQ_MULTI:
            begin
                n = (w.pop_count < shadow_fill) ? w.pop_count : shadow_fill;
                if (n > MAX_RESULTS)
                    n = MAX_RESULTS;
                if (n > deepest_multi)
                    deepest_multi = n;
                if (n == 0)
                begin
                    multi_calls++;
                    note_result('0, STAT_NONE, 1'b1);
                end
                for (i = 0; i < n; i++)
                begin
                    shadow_fill--;
                    v = shadow_mem[shadow_fill];
                    pop_cnt++;
                    multi_elems++;
                    if (i == n - 1)
                        multi_calls++;
                    note_result(v, STAT_POPPED, i == n - 1);
                end
            end
            default:
            begin
                // reserved request code: no result, nothing changes
            end
        endcase
    endfunction

    // compare one result word with the oldest expectation
    task automatic check_result(input rsp_word_t got);
        rsp_word_t want;
        if (expected_rsp.size() == 0)
        begin
            $error("result word with nothing expected: %p", got);
            errors++;
            return;
        end
        want = expected_rsp.pop_front();
        results_seen++;
        if (got.popped_value !== want.popped_value)
        begin
            $error("popped_value: expected %0d, got %0d", want.popped_value, got.popped_value);
            errors++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            errors++;
        end
        if (got.occupancy !== want.occupancy)
        begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
            errors++;
        end
        if (got.push_total !== want.push_total)
        begin
            $error("push_total: expected %0d, got %0d", want.push_total, got.push_total);
            errors++;
        end
        if (got.pop_total !== want.pop_total)
        begin
            $error("pop_total: expected %0d, got %0d", want.pop_total, got.pop_total);
            errors++;
        end
        if (got.multipop_elements !== want.multipop_elements)
        begin
            $error("multipop_elements: expected %0d, got %0d",
                   want.multipop_elements, got.multipop_elements);
            errors++;
        end
        if (got.multipop_calls !== want.multipop_calls)
        begin
            $error("multipop_calls: expected %0d, got %0d",
                   want.multipop_calls, got.multipop_calls);
            errors++;
        end
    endtask

    // monitor: accepted requests feed the predictor, results are checked
    always @(posedge clk)
    begin
        req_taken <= rst_n && req_valid && req_ready;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                predict_stack(req);
                words_taken++;
            end
            if (rsp_valid && rsp_ready)
                check_result(rsp);
        end
    end

    // request driver, holds a word until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || req_taken)
        begin
            if (pending_req.size() > 0 &&
                !(($urandom_range(99) < send_idle_pct) && !steady))
            begin
                req_valid <= 1'b1;
                req       <= pending_req.pop_front();
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // result back-pressure, with stretches of no idling on either side
    always @(negedge clk)
    begin
        if (stretch_left == 0)
        begin
            stretch_left <= $urandom_range(60, 10);
            steady       <= ($urandom_range(3) == 0);
        end
        else
        begin
            stretch_left <= stretch_left - 1;
        end
        rsp_ready <= rst_n && !(($urandom_range(99) < stall_pct) && !steady);
    end

    task automatic load_item(input logic [1:0] kind, input value_t v, input logic [7:0] cnt);
        req_word_t w;
        w.req_type   = kind;
        w.push_value = v;
        w.pop_count  = cnt;
        pending_req.push_back(w);
        words_loaded++;
    endtask

    function automatic value_t random_value();
        case ($urandom_range(19))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // random push runs mixed with pops, multipops and reserved request codes
    task automatic load_random_mix(input int n);
        int made;
        int run;
        int i;
        int pick;
        logic [7:0] amount;
        made = 0;
        while (made < n)
        begin
            if ($urandom_range(1) == 1)
            begin
                run = $urandom_range(18, 1);
                for (i = 0; i < run; i++)
                begin
                    load_item(REQ_PUSH, random_value(), 8'($urandom_range(255)));
                    made++;
                end
            end
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                load_item(REQ_RESERVED, random_value(), 8'($urandom_range(255)));
            end
            else if (pick < 40)
            begin
                load_item(REQ_POP, random_value(), 8'($urandom_range(255)));
                made++;
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 60)
                    amount = 8'($urandom_range(5));
                else if (pick < 85)
                    amount = 8'($urandom_range(20, 6));
                else
                    amount = 8'($urandom_range(255));
                load_item(REQ_MULTI, random_value(), amount);
                made++;
            end
        end
    endtask

    // wait until every word is taken and answered, then let the block settle
    task automatic drain_and_settle();
        while (words_taken != words_loaded || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [4:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cap_setting = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stimulus sequence
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset capacity: empty-stack cases, field extremes, reserved code
        load_item(REQ_POP,   '0, 8'd0);
        load_item(REQ_MULTI, '0, 8'd0);
        load_item(REQ_PUSH,  32'sh7FFFFFFF, 8'd0);
        load_item(REQ_PUSH,  32'sh80000000, 8'd255);
        load_item(REQ_PUSH,  '0, 8'd0);
        load_item(REQ_PUSH,  -32'sd1, 8'd255);
        load_item(REQ_RESERVED, -32'sd1, 8'd255);
        load_item(REQ_MULTI, '0, 8'd0);
        load_item(REQ_MULTI, '0, 8'd2);
        load_item(REQ_POP,   '0, 8'd0);
        load_item(REQ_MULTI, '0, 8'd255);
        load_item(REQ_MULTI, '0, 8'd255);
        drain_and_settle();

        // capacity of one, then zero with an entry still held
        write_capacity(5'd1);
        load_item(REQ_PUSH, 32'sh12345678, 8'd0);
        load_item(REQ_PUSH, 32'sh0BADF00D, 8'd0);
        drain_and_settle();
        write_capacity(5'd0);
        load_item(REQ_PUSH, 32'sh55555555, 8'd0);
        load_item(REQ_POP,  '0, 8'd0);
        load_item(REQ_POP,  '0, 8'd0);
        drain_and_settle();

        // capacity lowered below the occupancy
        write_capacity(5'd3);
        load_item(REQ_PUSH, 32'sh00000011, 8'd0);
        load_item(REQ_PUSH, 32'sh00000022, 8'd0);
        load_item(REQ_PUSH, 32'sh00000033, 8'd0);
        load_item(REQ_PUSH, 32'sh00000044, 8'd0);
        drain_and_settle();
        write_capacity(5'd1);
        load_item(REQ_PUSH, 32'sh00000055, 8'd0);
        load_item(REQ_POP,  '0, 8'd0);
        load_item(REQ_POP,  '0, 8'd0);
        load_item(REQ_PUSH, 32'sh00000066, 8'd0);
        load_item(REQ_POP,  '0, 8'd0);
        load_item(REQ_PUSH, 32'sh00000077, 8'd0);
        drain_and_settle();

        // random phases: capacity above depth, no idling
        write_capacity(5'd31);
        load_random_mix(60);
        drain_and_settle();

        // sender idle most of the time
        write_capacity(5'd7);
        send_idle_pct = 78;
        load_random_mix(60);
        drain_and_settle();

        // receiver stalling most of the time
        write_capacity(5'd16);
        send_idle_pct = 0;
        stall_pct     = 78;
        load_random_mix(60);
        drain_and_settle();

        // both sides idling now and then
        write_capacity(5'd12);
        send_idle_pct = 26;
        stall_pct     = 26;
        load_random_mix(60);
        drain_and_settle();

        $display("covered %0d request words and %0d result words, capacities 0 to 31",
                 words_taken, results_seen);
        $display("%0d overflows, %0d underflows, %0d multipop calls, deepest multipop %0d",
                 overflows, underflows, multi_calls, deepest_multi);
        if (errors == 0)
            $display("PASS lifo_stack_with_multipop");
        else
            $display("FAIL lifo_stack_with_multipop");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("FAIL lifo_stack_with_multipop");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/lstk_pkg.sv
rtl/lstk_cell.sv
rtl/lifo_stack_with_multipop.sv
dv/lifo_stack_with_multipop_tb.sv
